// ----- rtl/cfb_pkg.sv -----
// ----------------------------------------------------------------------------
// cfb_pkg: shared types, constants and functions of the command frame builder
// Frame layout, register indexes and the byte-wise CRC-16 update.
// ----------------------------------------------------------------------------
`default_nettype none

package cfb_pkg;

  localparam int FRAME_BYTES = 18;   // bytes per frame, CRC included
  localparam int CRC_BYTES   = 16;   // bytes covered by the CRC
  localparam int POS_W       = 5;    // frame byte counter width
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [15:0] CRC_TOP_BIT = 16'h8000;
  localparam logic [15:0] POLY_RESET  = 16'h1021;
  localparam logic [15:0] START_RESET = 16'hFFFF;

  localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(CRC_BYTES);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_BYTES - 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CRC_POLY  = 1'b0,
    REG_CRC_START = 1'b1
  } cfg_reg_t;

  // command_type [15:0], command_argument [31:16],
  // register_address [47:32], response_length [63:48]
  typedef logic [63:0] request_t;

  typedef struct packed {
    request_t    req;
    logic [15:0] crc;
  } stage_t;

  // Frame byte for a payload position (0..15); unused positions are zero.
  function automatic logic [7:0] payload_byte(request_t req, logic [POS_W-1:0] pos);
    logic [7:0] b;
    b = 8'h00;
    case (pos)
      5'd0:  b = req[7:0];
      5'd1:  b = req[15:8];
      5'd2:  b = req[23:16];
      5'd3:  b = req[31:24];
      5'd4:  b = req[39:32];
      5'd5:  b = req[47:40];
      5'd12: b = req[55:48];
      5'd13: b = req[63:56];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // MSB-first CRC update by one byte.
  function automatic logic [15:0] crc_feed(logic [15:0] crc_in, logic [7:0] b,
                                           logic [15:0] poly);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP_BIT) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/command_frame_builder_crc16_top.sv -----
// ----------------------------------------------------------------------------
// command_frame_builder_crc16_top: command frame builder with CRC-16
// Turns one 4-word command request into an 18-byte frame with trailing CRC.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*): one transfer is one command request, four 16-bit
//   words in s_tdata. Master stream (m_*): one transfer is one frame byte,
//   byte 0 first; m_tlast marks byte 17, the CRC high byte.
//   Frame: words little-endian at bytes 0-1, 2-3, 4-5 and 12-13, zeros
//   elsewhere, CRC-16 (MSB-first) over bytes 0-15 at bytes 16 (low) and 17.
//   Config port: cfg_we writes cfg_wdata to register cfg_index (0 polynomial,
//   1 start value); write only while no frame is in flight.
// Pipeline: a request passes through 16 CRC stages, one byte folded in per
//   stage, then the frame register, before byte 0 of its frame is offered.
// Throughput: the one-byte serializer takes no new frame before the last
//   byte of the current one goes out. The CRC pipeline takes a request every
//   cycle unless stalled, and holds up to 16 more while the serializer drains.
// Reset: valid bits, serializer and byte counter clear; polynomial returns to
//   0x1021 and start value to 0xFFFF.
// Stall: when m_tready is low the current byte holds; once the pipeline tail
//   is occupied and cannot move into the frame register, s_tready drops and
//   the whole CRC pipeline holds.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_builder_crc16_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // slave stream, tdata: command_type, command_argument,
  // register_address, response_length (16 bits each, from bit 0 up)
  input  wire logic                            s_tvalid,
  output      logic                            s_tready,
  input  wire logic [63:0]                     s_tdata,
  // master stream, tdata: frame_byte (8 bits)
  output      logic                            m_tvalid,
  input  wire logic                            m_tready,
  output      logic [7:0]                      m_tdata,
  output      logic                            m_tlast,
  // config write port
  input  wire logic                            cfg_we,
  input  wire logic [cfb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [cfb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import cfb_pkg::*;

  // config registers
  logic [15:0] crc_poly;
  logic [15:0] crc_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_poly  <= POLY_RESET;
      crc_start <= START_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CRC_POLY:  crc_poly  <= cfg_wdata;
        REG_CRC_START: crc_start <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // CRC pipeline: stage i holds the CRC after frame bytes 0..i
  stage_t              stage  [CRC_BYTES];
  logic [CRC_BYTES-1:0] stage_vld;
  logic                advance;
  logic                load;

  // frame register / serializer
  request_t         frame_req;
  logic [15:0]      frame_crc;
  logic             busy;
  logic [POS_W-1:0] pos;
  logic             out_xfer;
  logic             out_done;

  assign out_xfer = busy && m_tready;
  assign out_done = out_xfer && (pos == POS_LAST);
  assign load     = stage_vld[CRC_BYTES-1] && (!busy || out_done);
  assign advance  = !stage_vld[CRC_BYTES-1] || load;
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= '0;
    end else if (advance) begin
      stage_vld <= {stage_vld[CRC_BYTES-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage[0].req <= s_tdata;
      stage[0].crc <= crc_feed(crc_start, payload_byte(s_tdata, POS_W'(0)), crc_poly);
    end
  end

  for (genvar i = 1; i < CRC_BYTES; i++) begin : g_crc_stage
    always_ff @(posedge clk) begin
      if (advance) begin
        stage[i].req <= stage[i-1].req;
        stage[i].crc <= crc_feed(stage[i-1].crc,
                                 payload_byte(stage[i-1].req, POS_W'(i)), crc_poly);
      end
    end
  end

  // serializer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        pos  <= '0;
      end else if (out_done) begin
        busy <= 1'b0;
        pos  <= '0;
      end else if (out_xfer) begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_req <= stage[CRC_BYTES-1].req;
      frame_crc <= stage[CRC_BYTES-1].crc;
    end
  end

  // byte select from the held frame
  always_comb begin
    if (pos == POS_CRC_LO) begin
      m_tdata = frame_crc[7:0];
    end else if (pos == POS_LAST) begin
      m_tdata = frame_crc[15:8];
    end else begin
      m_tdata = payload_byte(frame_req, pos);
    end
  end

  assign m_tvalid = busy;
  assign m_tlast  = (pos == POS_LAST);

endmodule

`default_nettype wire

// ----- rtl/cfb_checker.sv -----
// ----------------------------------------------------------------------------
// cfb_checker: port-level checks for the command frame builder
// Frame length, in-flight accounting and output hold under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic        m_tlast
);
  import cfb_pkg::*;

  logic [POS_W-1:0] byte_cnt;
  logic [5:0]       in_flight;
  logic             in_xfer;
  logic             out_xfer;
  logic             frame_end;

  assign in_xfer   = s_tvalid && s_tready;
  assign out_xfer  = m_tvalid && m_tready;
  assign frame_end = out_xfer && m_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_cnt  <= '0;
      in_flight <= '0;
    end else begin
      if (frame_end) begin
        byte_cnt <= '0;
      end else if (out_xfer) begin
        byte_cnt <= byte_cnt + POS_W'(1);
      end
      in_flight <= in_flight + 6'(in_xfer) - 6'(frame_end);
    end
  end

  // tlast exactly on the 18th byte
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_xfer |-> (m_tlast == (byte_cnt == POS_LAST)))
    else $error("tlast not on frame byte 17");

  // no output without an accepted request
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (in_flight != 6'd0))
    else $error("output with no request in flight");

  // at most pipeline depth plus frame register in flight
  a_depth: assert property (@(posedge clk) disable iff (rst)
    in_flight <= 6'(CRC_BYTES + 1))
    else $error("too many requests in flight");

  // stalled byte holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output changed under stall");

endmodule

bind command_frame_builder_crc16_top cfb_checker u_cfb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
